>>> rtl/mfs_pkg.sv
`timescale 1ns / 1ps
package mfs_pkg;

   // store geometry
   localparam int NUM_USERS    = 1024;
   localparam int NUM_ITEMS    = 2048;
   localparam int NUM_FEATURES = 64;
   localparam int USER_W       = $clog2(NUM_USERS);
   localparam int ITEM_W       = $clog2(NUM_ITEMS);
   localparam int FEAT_W       = $clog2(NUM_FEATURES);
   localparam int UF_DEPTH     = NUM_USERS * NUM_FEATURES;
   localparam int IF_DEPTH     = NUM_ITEMS * NUM_FEATURES;
   localparam int UF_AW        = $clog2(UF_DEPTH);
   localparam int IF_AW        = $clog2(IF_DEPTH);

   // command queue between front and back
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   // csr register indexes
   localparam logic [1:0] CSR_GLOBAL_MEAN = 2'd0;
   localparam logic [1:0] CSR_LEARN_RATE  = 2'd1;
   localparam logic [1:0] CSR_REG_WEIGHT  = 2'd2;

   // reset values of the csr registers
   localparam logic signed [31:0] GLOBAL_MEAN_RESET = 32'sd229376;
   localparam logic [15:0]        LEARN_RATE_RESET  = 16'd2621;
   localparam logic [15:0]        REG_WEIGHT_RESET  = 16'd9830;

   localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

   typedef enum logic [2:0] {
      OP_LOAD_UF   = 3'd0,
      OP_LOAD_IF   = 3'd1,
      OP_LOAD_UB   = 3'd2,
      OP_LOAD_IB   = 3'd3,
      OP_TRAIN     = 3'd4,
      OP_PREDICT   = 3'd5,
      OP_RSVD6     = 3'd6,
      OP_RSVD7     = 3'd7
   } op_type;

   typedef enum logic {
      KIND_PREDICTION = 1'b0,
      KIND_ERROR      = 1'b1
   } kind_type;

   typedef struct packed {
      op_type              op;
      logic [USER_W-1:0]   user_id;
      logic [ITEM_W-1:0]   item_id;
      logic [FEAT_W-1:0]   feature_index;
      logic signed [31:0]  load_value;
      logic [2:0]          rating_value;
   } cmd_type;

   typedef struct packed {
      logic signed [31:0] global_mean;
      logic [15:0]        learn_rate;
      logic [15:0]        reg_weight;
   } cfg_type;

   typedef struct packed {
      logic    push;
      cmd_type data;
   } push_type;

   typedef struct packed {
      logic    empty;
      logic    full;
      cmd_type data;
   } queue_status_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_DISPATCH,
      BK_BIAS,
      BK_PRED,
      BK_CLAMP,
      BK_ERR,
      BK_UMUL,
      BK_USUB,
      BK_UMUL2,
      BK_UADD,
      BK_FREAD,
      BK_FWAIT
   } back_state_type;

   typedef enum logic [1:0] {
      TG_UB,
      TG_IB,
      TG_UF,
      TG_IF
   } target_type;

   // saturate to signed 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      if (x > 64'sd2147483647)
         return 32'sh7fffffff;
      else if (x < -64'sd2147483648)
         return 32'sh80000000;
      else
         return x[31:0];
   endfunction

   // back to q16.16, rounding half up
   function automatic logic signed [63:0] rnd16(input logic signed [63:0] x);
      logic signed [63:0] y;
      y = x + 64'sd32768;
      return y >>> 16;
   endfunction

endpackage

>>> rtl/matrix_factorization_sgd.sv
`timescale 1ns / 1ps
// channel   handshake                    payload
// req       start / busy                 op user_id item_id feature_index load_value rating
// rsp       rsp_valid (one-cycle strobe) result_value result_kind
// csr       csr_valid / csr_ready        csr_index csr_data
//
// items pass a two-entry queue from the front to a sequencer that owns the stores
// load: popped in idle and written in dispatch; predict: a pipelined read-multiply-add
// pass over 64 features; train: the prediction pass plus two four-step bias updates
// and, for each feature, a read, a wait and the user and item factor updates
// reset is synchronous and clears control state; stores hold garbage until loaded
// busy rises only while the queue is full; results cannot be stalled
module matrix_factorization_sgd import mfs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [2:0]          req_op,
   input  logic [USER_W-1:0]   req_user_id,
   input  logic [ITEM_W-1:0]   req_item_id,
   input  logic [FEAT_W-1:0]   req_feature_index,
   input  logic signed [31:0]  req_load_value,
   input  logic [2:0]          req_rating_value,
   output logic                rsp_valid,
   output logic signed [31:0]  rsp_result_value,
   output logic                rsp_result_kind,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_data
);

   cfg_type          cfg_ff, cfg_in;
   push_type         push;
   queue_status_type queue;
   logic             pop;

   // csr registers
   assign csr_ready = 1'b1;
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_GLOBAL_MEAN: cfg_in.global_mean = $signed(csr_data);
            CSR_LEARN_RATE:  cfg_in.learn_rate  = csr_data[15:0];
            CSR_REG_WEIGHT:  cfg_in.reg_weight  = csr_data[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.global_mean <= GLOBAL_MEAN_RESET;
         cfg_ff.learn_rate  <= LEARN_RATE_RESET;
         cfg_ff.reg_weight  <= REG_WEIGHT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mfs_front u_front (
      .start             (start),
      .busy              (busy),
      .req_op            (req_op),
      .req_user_id       (req_user_id),
      .req_item_id       (req_item_id),
      .req_feature_index (req_feature_index),
      .req_load_value    (req_load_value),
      .req_rating_value  (req_rating_value),
      .queue_full        (queue.full),
      .push              (push)
   );

   mfs_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .status (queue)
   );

   mfs_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .queue            (queue),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_result_value (rsp_result_value),
      .rsp_result_kind  (rsp_result_kind)
   );

   // two results never come on adjacent cycles
   a_rsp_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobes on adjacent cycles");

   // the queue is empty right after reset
   a_reset_not_busy: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !busy)
      else $error("busy right after reset");

   // no result in the cycle right after reset
   a_reset_no_rsp: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result right after reset");

endmodule

>>> rtl/mfs_front.sv
`timescale 1ns / 1ps
module mfs_front import mfs_pkg::*; (
   input  logic                start,
   output logic                busy,
   input  logic [2:0]          req_op,
   input  logic [USER_W-1:0]   req_user_id,
   input  logic [ITEM_W-1:0]   req_item_id,
   input  logic [FEAT_W-1:0]   req_feature_index,
   input  logic signed [31:0]  req_load_value,
   input  logic [2:0]          req_rating_value,
   input  logic                queue_full,
   output push_type            push
);

   logic accept;
   logic op_known;

   // hold off while the queue has no room
   assign busy   = queue_full;
   assign accept = start && !busy;

   // classify: reserved ops are dropped here and never reach the back
   always_comb begin
      unique case (op_type'(req_op))
         OP_LOAD_UF, OP_LOAD_IF, OP_LOAD_UB, OP_LOAD_IB,
         OP_TRAIN, OP_PREDICT: op_known = 1'b1;
         default:              op_known = 1'b0;
      endcase
   end

   // queue write
   always_comb begin
      push.push               = accept && op_known;
      push.data.op            = op_type'(req_op);
      push.data.user_id       = req_user_id;
      push.data.item_id       = req_item_id;
      push.data.feature_index = req_feature_index;
      push.data.load_value    = req_load_value;
      push.data.rating_value  = req_rating_value;
   end

endmodule

>>> rtl/mfs_queue.sv
`timescale 1ns / 1ps
module mfs_queue import mfs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  push_type         push,
   input  logic             pop,
   output queue_status_type status
);

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push.push && !pop)
         count_in = count_ff + 1'b1;
      else if (pop && !push.push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push.push)
         entry_ff[wr_ptr_ff] <= push.data;
   end

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.data  = entry_ff[rd_ptr_ff];

endmodule

>>> rtl/mfs_back.sv
`timescale 1ns / 1ps
module mfs_back import mfs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  queue_status_type   queue,
   output logic               pop,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_result_value,
   output logic               rsp_result_kind
);

   // factor and bias stores
   logic signed [31:0] uf_mem [UF_DEPTH];
   logic signed [31:0] if_mem [IF_DEPTH];
   logic signed [31:0] ub_mem [NUM_USERS];
   logic signed [31:0] ib_mem [NUM_ITEMS];

   back_state_type     state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [FEAT_W:0]    cnt_ff, cnt_in;
   logic               v1_ff, v1_in;
   logic               v2_ff, v2_in;
   target_type         tgt_ff, tgt_in;
   logic signed [63:0] acc_ff, acc_in;
   logic signed [63:0] p_ff, p_in;
   logic signed [63:0] q_ff, q_in;
   logic signed [63:0] r_ff, r_in;
   logic signed [31:0] inner_ff, inner_in;
   logic signed [31:0] pred_ff, pred_in;
   logic signed [31:0] err_ff, err_in;
   logic signed [31:0] ub_ff, ub_in;
   logic signed [31:0] ib_ff, ib_in;
   logic signed [31:0] u_ff, u_in;
   logic signed [31:0] v_ff, v_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_value_ff, rsp_value_in;
   logic               rsp_kind_ff, rsp_kind_in;

   logic signed [31:0] uf_rd_ff, if_rd_ff, ub_rd_ff, ib_rd_ff;

   logic [UF_AW-1:0]   uf_addr;
   logic [IF_AW-1:0]   if_addr;
   logic               uf_we, if_we, ub_we, ib_we;
   logic signed [31:0] uf_wd, if_wd, ub_wd, ib_wd;

   logic signed [31:0] cur;
   logic signed [31:0] other;
   logic signed [63:0] drive;
   logic signed [31:0] new_val;
   logic signed [31:0] sat_acc;
   logic               last_feat;

   assign last_feat = (cnt_ff[FEAT_W-1:0] == FEAT_W'(NUM_FEATURES - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE:     if (!queue.empty) state_in = BK_DISPATCH;
         BK_DISPATCH: begin
            if (cmd_ff.op == OP_TRAIN || cmd_ff.op == OP_PREDICT)
               state_in = BK_BIAS;
            else
               state_in = BK_IDLE;
         end
         BK_BIAS:     state_in = BK_PRED;
         BK_PRED:     if (cnt_ff[FEAT_W] && !v1_ff && !v2_ff) state_in = BK_CLAMP;
         BK_CLAMP:    state_in = (cmd_ff.op == OP_PREDICT) ? BK_IDLE : BK_ERR;
         BK_ERR:      state_in = BK_UMUL;
         BK_UMUL:     state_in = BK_USUB;
         BK_USUB:     state_in = BK_UMUL2;
         BK_UMUL2:    state_in = BK_UADD;
         BK_UADD: begin
            unique case (tgt_ff)
               TG_UB:   state_in = BK_UMUL;
               TG_IB:   state_in = BK_FREAD;
               TG_UF:   state_in = BK_UMUL;
               TG_IF:   state_in = last_feat ? BK_IDLE : BK_FREAD;
               default: state_in = BK_IDLE;
            endcase
         end
         BK_FREAD:    state_in = BK_FWAIT;
         BK_FWAIT:    state_in = BK_UMUL;
         default:     state_in = BK_IDLE;
      endcase
   end

   // operand selection for the shared update sequence
   always_comb begin
      unique case (tgt_ff)
         TG_UB:   begin cur = ub_ff; other = '0;   end
         TG_IB:   begin cur = ib_ff; other = '0;   end
         TG_UF:   begin cur = u_ff;  other = v_ff; end
         TG_IF:   begin cur = v_ff;  other = u_ff; end
         default: begin cur = '0;    other = '0;   end
      endcase
      drive   = (tgt_ff == TG_UB || tgt_ff == TG_IB) ? 64'(err_ff) : rnd16(p_ff);
      new_val = sat32(64'(cur) + rnd16(r_ff));
      sat_acc = sat32(acc_ff);
   end

   // datapath and outputs
   always_comb begin
      pop          = 1'b0;
      cmd_in       = cmd_ff;
      cnt_in       = cnt_ff;
      v1_in        = 1'b0;
      v2_in        = 1'b0;
      tgt_in       = tgt_ff;
      acc_in       = acc_ff;
      p_in         = p_ff;
      q_in         = q_ff;
      r_in         = r_ff;
      inner_in     = inner_ff;
      pred_in      = pred_ff;
      err_in       = err_ff;
      ub_in        = ub_ff;
      ib_in        = ib_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      rsp_valid_in = 1'b0;
      rsp_value_in = rsp_value_ff;
      rsp_kind_in  = rsp_kind_ff;
      uf_addr      = {cmd_ff.user_id, cnt_ff[FEAT_W-1:0]};
      if_addr      = {cmd_ff.item_id, cnt_ff[FEAT_W-1:0]};
      uf_we        = 1'b0;
      if_we        = 1'b0;
      ub_we        = 1'b0;
      ib_we        = 1'b0;
      uf_wd        = new_val;
      if_wd        = new_val;
      ub_wd        = new_val;
      ib_wd        = new_val;
      unique case (state_ff)
         BK_IDLE: begin
            if (!queue.empty) begin
               pop    = 1'b1;
               cmd_in = queue.data;
            end
         end
         BK_DISPATCH: begin
            // loads finish here; bias reads for train and predict start here
            uf_wd  = cmd_ff.load_value;
            if_wd  = cmd_ff.load_value;
            ub_wd  = cmd_ff.load_value;
            ib_wd  = cmd_ff.load_value;
            cnt_in = '0;
            unique case (cmd_ff.op)
               OP_LOAD_UF: begin
                  uf_addr = {cmd_ff.user_id, cmd_ff.feature_index};
                  uf_we   = 1'b1;
               end
               OP_LOAD_IF: begin
                  if_addr = {cmd_ff.item_id, cmd_ff.feature_index};
                  if_we   = 1'b1;
               end
               OP_LOAD_UB: ub_we = 1'b1;
               OP_LOAD_IB: ib_we = 1'b1;
               default: ;
            endcase
         end
         BK_BIAS: begin
            ub_in  = ub_rd_ff;
            ib_in  = ib_rd_ff;
            acc_in = 64'(cfg.global_mean) + 64'(ub_rd_ff) + 64'(ib_rd_ff);
         end
         BK_PRED: begin
            // read, multiply, accumulate pipeline over the features
            if (!cnt_ff[FEAT_W]) begin
               cnt_in = cnt_ff + 1'b1;
               v1_in  = 1'b1;
            end
            v2_in = v1_ff;
            p_in  = uf_rd_ff * if_rd_ff;
            if (v2_ff)
               acc_in = acc_ff + rnd16(p_ff);
         end
         BK_CLAMP: begin
            pred_in = (sat_acc < ONE_Q16) ? ONE_Q16 : sat_acc;
            if (cmd_ff.op == OP_PREDICT) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = (sat_acc < ONE_Q16) ? ONE_Q16 : sat_acc;
               rsp_kind_in  = KIND_PREDICTION;
            end
         end
         BK_ERR: begin
            err_in = sat32($signed({45'd0, cmd_ff.rating_value, 16'd0}) - 64'(pred_ff));
            tgt_in = TG_UB;
            cnt_in = '0;
         end
         BK_UMUL: begin
            p_in = err_ff * other;
            q_in = $signed({1'b0, cfg.reg_weight}) * cur;
         end
         BK_USUB:  inner_in = sat32(drive - rnd16(q_ff));
         BK_UMUL2: r_in = $signed({1'b0, cfg.learn_rate}) * inner_ff;
         BK_UADD: begin
            unique case (tgt_ff)
               TG_UB: begin
                  ub_we  = 1'b1;
                  tgt_in = TG_IB;
               end
               TG_IB: ib_we = 1'b1;
               TG_UF: begin
                  uf_we  = 1'b1;
                  u_in   = new_val;
                  tgt_in = TG_IF;
               end
               TG_IF: begin
                  if_we = 1'b1;
                  if (last_feat) begin
                     rsp_valid_in = 1'b1;
                     rsp_value_in = err_ff;
                     rsp_kind_in  = KIND_ERROR;
                  end else begin
                     cnt_in = cnt_ff + 1'b1;
                  end
               end
               default: ;
            endcase
         end
         BK_FREAD: ;
         BK_FWAIT: begin
            u_in   = uf_rd_ff;
            v_in   = if_rd_ff;
            tgt_in = TG_UF;
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      cnt_ff       <= cnt_in;
      tgt_ff       <= tgt_in;
      acc_ff       <= acc_in;
      p_ff         <= p_in;
      q_ff         <= q_in;
      r_ff         <= r_in;
      inner_ff     <= inner_in;
      pred_ff      <= pred_in;
      err_ff       <= err_in;
      ub_ff        <= ub_in;
      ib_ff        <= ib_in;
      u_ff         <= u_in;
      v_ff         <= v_in;
      rsp_value_ff <= rsp_value_in;
      rsp_kind_ff  <= rsp_kind_in;
   end

   // user factor store
   always_ff @(posedge clock) begin
      if (uf_we)
         uf_mem[uf_addr] <= uf_wd;
   end
   always_ff @(posedge clock) begin
      uf_rd_ff <= uf_mem[uf_addr];
   end

   // item factor store
   always_ff @(posedge clock) begin
      if (if_we)
         if_mem[if_addr] <= if_wd;
   end
   always_ff @(posedge clock) begin
      if_rd_ff <= if_mem[if_addr];
   end

   // user bias store
   always_ff @(posedge clock) begin
      if (ub_we)
         ub_mem[cmd_ff.user_id] <= ub_wd;
   end
   always_ff @(posedge clock) begin
      ub_rd_ff <= ub_mem[cmd_ff.user_id];
   end

   // item bias store
   always_ff @(posedge clock) begin
      if (ib_we)
         ib_mem[cmd_ff.item_id] <= ib_wd;
   end
   always_ff @(posedge clock) begin
      ib_rd_ff <= ib_mem[cmd_ff.item_id];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_result_kind  = rsp_kind_ff;

endmodule
